@@ hw/rtl/remote_frame_decoder_macros.svh @@
// Assertion helpers for the decoder RTL.
`ifndef REMOTE_FRAME_DECODER_MACROS_SVH
`define REMOTE_FRAME_DECODER_MACROS_SVH

// Checked on every rising clk_i edge outside reset.
`define RFD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising clk_i edge, reset included.
`define RFD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ hw/rtl/rfd_pkg.sv @@
`default_nettype none
package rfd_pkg;

  localparam int unsigned StoreDepth = 17;
  localparam int unsigned PosW       = 5;

  localparam logic [PosW-1:0] PosDecode = 5'd17;
  localparam logic [PosW-1:0] PosDone   = 5'd18;

  localparam logic [10:0] OffsetReset = 11'd1024;
  localparam logic [9:0]  LimitReset  = 10'd700;

  typedef enum logic {
    ACT_BYTE  = 1'b0,
    ACT_QUERY = 1'b1
  } action_e;

  typedef enum logic {
    KIND_FRAME = 1'b0,
    KIND_QUERY = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    CFG_OFFSET = 2'd0,
    CFG_LIMIT  = 2'd1
  } cfg_idx_e;

  // bytes 0..16 of a frame, index 0 received first
  typedef logic [StoreDepth-1:0][7:0] store_t;

  typedef struct packed {
    logic [43:0] stick_channels;
    logic [15:0] dial;
    logic [1:0]  switch_right;
    logic [1:0]  switch_left;
    logic [15:0] mouse_x;
    logic [15:0] mouse_y;
    logic [15:0] mouse_z;
    logic [15:0] mouse_buttons;
    logic [15:0] keys;
  } rec_t;

endpackage
`default_nettype wire

@@ hw/rtl/rfd_frame_buf.sv @@
`default_nettype none
module rfd_frame_buf import rfd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       byte_en_i,
  input  logic [7:0] rx_byte_i,
  input  logic       frame_start_i,
  output logic       decode_o,
  output store_t     store_o
);

  logic [PosW-1:0] pos_q, pos_d, pos_eff;
  store_t          store_q, store_d;

  always_comb begin
    pos_eff  = frame_start_i ? '0 : pos_q;
    decode_o = (pos_eff == PosDecode);
    pos_d    = pos_q;
    store_d  = store_q;
    if (byte_en_i) begin
      if (pos_eff < PosDecode) begin
        // shift line: newest byte enters at the top
        store_d = {rx_byte_i, store_q[StoreDepth-1:1]};
        pos_d   = PosW'(pos_eff + 5'd1);
      end else if (decode_o) begin
        pos_d = PosDone;
      end else begin
        pos_d = pos_eff;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    store_q <= store_d;
  end

  assign store_o = store_q;

endmodule
`default_nettype wire

@@ hw/rtl/rfd_unpack.sv @@
`default_nettype none
module rfd_unpack import rfd_pkg::*; (
  input  store_t      store_i,
  input  logic [7:0]  last_byte_i,
  input  logic [10:0] offset_i,
  input  logic [9:0]  limit_i,
  output rec_t        rec_o,
  output logic [15:0] keys_raw_o,
  output logic        error_o
);

  logic [10:0] raw   [4];
  logic [11:0] diff  [4];
  logic [11:0] mag   [4];
  logic [3:0]  over;
  logic [1:0]  sw_r, sw_l;
  rec_t        rec;

  always_comb begin
    raw[0] = {store_i[1][2:0], store_i[0]};
    raw[1] = {store_i[2][5:0], store_i[1][7:3]};
    raw[2] = {store_i[4][0], store_i[3], store_i[2][7:6]};
    raw[3] = {store_i[5][3:0], store_i[4][7:1]};
    for (int i = 0; i < 4; i++) begin
      diff[i] = {1'b0, raw[i]} - {1'b0, offset_i};
      mag[i]  = diff[i][11] ? 12'(-diff[i]) : diff[i];
      over[i] = (mag[i] > {2'b00, limit_i});
    end
    sw_r = store_i[5][5:4];
    sw_l = store_i[5][7:6];

    rec.stick_channels = {diff[3][10:0], diff[2][10:0], diff[1][10:0], diff[0][10:0]};
    rec.dial           = {last_byte_i, store_i[16]} - {5'd0, offset_i};
    rec.switch_right   = sw_r;
    rec.switch_left    = sw_l;
    rec.mouse_x        = 16'(-{store_i[9], store_i[8]});
    rec.mouse_y        = 16'(-{store_i[7], store_i[6]});
    rec.mouse_z        = {store_i[11], store_i[10]};
    rec.mouse_buttons  = {store_i[13], store_i[12]};
    rec.keys           = {store_i[15], store_i[14]};

    keys_raw_o = rec.keys;
    error_o    = (sw_r == 2'd0) || (sw_l == 2'd0) || (|over);
    rec_o      = error_o ? '0 : rec;
  end

endmodule
`default_nettype wire

@@ hw/rtl/remote_frame_decoder.sv @@
// Remote-control frame decoder.
// Input channel (in_valid_i / in_stall_o): one transaction is either a frame
// byte (action_i = 0) or a press-once key query (action_i = 1). frame_start_i
// restarts the byte count; the 18th byte of a frame yields one frame record,
// later bytes are dropped until the next start. A query always yields one
// answer.
// Output channel (out_valid_o / out_stall_i): one result per record or answer.
// Config channel (cfg_valid_i / cfg_ready_o): always ready; index 0 is the
// channel offset, index 1 the stick limit. Write only while the block is idle.
// Throughput: one transaction per cycle while in_stall_o is low. A result
// passes from the input register through the decode logic into the result
// register.
// A stalled result holds in the result register; the input register keeps
// moving while its item gives no result, else in_stall_o rises during such a hold.
// Reset empties both registers, zeroes byte count and key tracking and loads
// offset 1024 and limit 700. The byte store itself is not cleared.
`default_nettype none
`include "remote_frame_decoder_macros.svh"
module remote_frame_decoder import rfd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               action_i,
  input  logic [7:0]         rx_byte_i,
  input  logic               frame_start_i,
  input  logic [15:0]        key_mask_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               result_kind_o,
  output logic [43:0]        stick_channels_o,
  output logic signed [15:0] dial_o,
  output logic [1:0]         switch_right_o,
  output logic [1:0]         switch_left_o,
  output logic signed [15:0] mouse_x_o,
  output logic signed [15:0] mouse_y_o,
  output logic signed [15:0] mouse_z_o,
  output logic [15:0]        mouse_buttons_o,
  output logic [15:0]        keys_o,
  output logic               frame_error_o,
  output logic               key_once_hit_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [10:0]        cfg_data_i
);

  logic [10:0] offset_q;
  logic [9:0]  limit_q;

  logic        s1_valid_q, s1_valid_d;
  logic        s1_action_q;
  logic [7:0]  s1_rx_q;
  logic        s1_start_q;
  logic [15:0] s1_mask_q;

  logic        in_accept, s1_fire, s1_query, s1_has_result;
  logic        decode, dec_error, hit;
  store_t      store;
  rec_t        rec;
  logic [15:0] keys_raw;

  logic [15:0] key_now_q, key_now_d;
  logic [15:0] key_changed_q, key_changed_d;
  logic [15:0] key_reported_q, key_reported_d;

  logic        out_valid_q, out_valid_d, out_load;
  logic        out_kind_q, out_err_q, out_hit_q;
  rec_t        out_rec_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= OffsetReset;
      limit_q  <= LimitReset;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_OFFSET: offset_q <= cfg_data_i;
        CFG_LIMIT:  limit_q  <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  // input register
  assign s1_query      = (s1_action_q == ACT_QUERY);
  assign s1_has_result = s1_query || decode;
  assign s1_fire       = s1_valid_q && (!s1_has_result || !out_valid_q || !out_stall_i);
  assign in_stall_o    = s1_valid_q && !s1_fire;
  assign in_accept     = in_valid_i && !in_stall_o;
  assign s1_valid_d    = in_accept || (s1_valid_q && !s1_fire);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_action_q <= action_i;
      s1_rx_q     <= rx_byte_i;
      s1_start_q  <= frame_start_i;
      s1_mask_q   <= key_mask_i;
    end
  end

  rfd_frame_buf u_frame_buf (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .byte_en_i     (s1_fire && !s1_query),
    .rx_byte_i     (s1_rx_q),
    .frame_start_i (s1_start_q),
    .decode_o      (decode),
    .store_o       (store)
  );

  rfd_unpack u_unpack (
    .store_i     (store),
    .last_byte_i (s1_rx_q),
    .offset_i    (offset_q),
    .limit_i     (limit_q),
    .rec_o       (rec),
    .keys_raw_o  (keys_raw),
    .error_o     (dec_error)
  );

  // key tracking and press-once query
  always_comb begin
    key_now_d      = key_now_q;
    key_changed_d  = key_changed_q;
    key_reported_d = key_reported_q;
    hit            = 1'b0;
    if (s1_query) begin
      if ((key_now_q & s1_mask_q) == '0) begin
        key_reported_d = key_reported_q & ~s1_mask_q;
      end else if (((key_changed_q & s1_mask_q) != '0) &&
                   ((key_reported_q & s1_mask_q) == '0)) begin
        key_reported_d = key_reported_q | s1_mask_q;
        hit            = 1'b1;
      end
    end else if (decode) begin
      key_changed_d = keys_raw ^ key_now_q;
      key_now_d     = dec_error ? '0 : keys_raw;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_now_q      <= '0;
      key_changed_q  <= '0;
      key_reported_q <= '0;
    end else if (s1_fire) begin
      key_now_q      <= key_now_d;
      key_changed_q  <= key_changed_d;
      key_reported_q <= key_reported_d;
    end
  end

  // result register
  assign out_load    = s1_fire && s1_has_result;
  assign out_valid_d = out_load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_kind_q <= s1_query ? KIND_QUERY : KIND_FRAME;
      out_rec_q  <= s1_query ? '0 : rec;
      out_err_q  <= !s1_query && dec_error;
      out_hit_q  <= hit;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign result_kind_o    = out_kind_q;
  assign stick_channels_o = out_rec_q.stick_channels;
  assign dial_o           = out_rec_q.dial;
  assign switch_right_o   = out_rec_q.switch_right;
  assign switch_left_o    = out_rec_q.switch_left;
  assign mouse_x_o        = out_rec_q.mouse_x;
  assign mouse_y_o        = out_rec_q.mouse_y;
  assign mouse_z_o        = out_rec_q.mouse_z;
  assign mouse_buttons_o  = out_rec_q.mouse_buttons;
  assign keys_o           = out_rec_q.keys;
  assign frame_error_o    = out_err_q;
  assign key_once_hit_o   = out_hit_q;

  `RFD_ASSERT(a_err_clears_rec, out_valid_o && frame_error_o |-> stick_channels_o == '0 && keys_o == '0 && switch_right_o == '0, "error record not cleared")
  `RFD_ASSERT(a_query_clean, out_valid_o && result_kind_o == KIND_QUERY |-> !frame_error_o && dial_o == '0 && mouse_x_o == '0, "query answer carries frame data")
  `RFD_ASSERT(a_hit_marks_reported, s1_fire && s1_query && hit |=> (key_reported_q & $past(s1_mask_q)) == $past(s1_mask_q), "reported mask not set after hit")
  `RFD_ASSERT_ALWAYS(a_stall_needs_item, in_stall_o |-> s1_valid_q, "input stalled with empty input register")

endmodule
`default_nettype wire

@@ test/remote_frame_checker.sv @@
`timescale 1ns / 100ps
module remote_frame_checker import rfd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic        action_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        frame_start_i,
  input  logic [15:0] key_mask_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic        result_kind_i,
  input  logic [43:0] stick_channels_i,
  input  logic [15:0] dial_i,
  input  logic [1:0]  switch_right_i,
  input  logic [1:0]  switch_left_i,
  input  logic [15:0] mouse_x_i,
  input  logic [15:0] mouse_y_i,
  input  logic [15:0] mouse_z_i,
  input  logic [15:0] mouse_buttons_i,
  input  logic [15:0] keys_i,
  input  logic        frame_error_i,
  input  logic        key_once_hit_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [10:0] cfg_data_i,
  output int          mismatches_o,
  output int          pending_o
);

  typedef struct packed {
    kind_e kind;
    rec_t  rec;
    logic  err;
    logic  hit;
  } answer_t;

  logic [7:0]  frame_bytes [StoreDepth];
  logic [4:0]  byte_pos;
  logic [15:0] keys_now;
  logic [15:0] keys_changed;
  logic [15:0] keys_reported;
  logic [10:0] offset;
  logic [9:0]  limit;
  answer_t     answers_due [$];

  task automatic report(input string msg);
    $display("[%0t] %s", $time, msg);
    mismatches_o++;
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got)
      report($sformatf("%s: expected %0h, got %0h", name, want, got));
  endtask

  // Updates the decoder state for one input transaction and queues any answer
  function automatic void decode_item(input action_e act, input logic [7:0] rx,
                                      input logic start, input logic [15:0] mask);
    answer_t     ans;
    logic [143:0] fr;
    logic [15:0] new_keys;
    logic [1:0]  sw_r;
    logic [1:0]  sw_l;
    logic        err;
    int          diff;
    ans = '0;
    if (act == ACT_QUERY) begin
      ans.kind = KIND_QUERY;
      if ((keys_now & mask) == 16'h0) begin
        keys_reported &= ~mask;
      end else if ((keys_changed & mask) != 16'h0 && (keys_reported & mask) == 16'h0) begin
        keys_reported |= mask;
        ans.hit = 1'b1;
      end
      answers_due.push_back(ans);
      return;
    end
    if (start) byte_pos = '0;
    if (byte_pos < PosDecode) begin
      frame_bytes[byte_pos] = rx;
      byte_pos++;
      return;
    end
    // bytes past the end of a frame are dropped
    if (byte_pos != PosDecode) return;
    byte_pos = PosDone;

    for (int i = 0; i < StoreDepth; i++) fr[8*i +: 8] = frame_bytes[i];
    fr[143:136] = rx;
    ans.kind = KIND_FRAME;
    new_keys = fr[127:112];
    keys_changed = new_keys ^ keys_now;
    keys_now = new_keys;
    sw_r = fr[45:44];
    sw_l = fr[47:46];
    err = (sw_r == 2'd0) || (sw_l == 2'd0);
    for (int i = 0; i < 4; i++) begin
      diff = int'(fr[11*i +: 11]) - int'(offset);
      if ((diff < 0 ? -diff : diff) > int'(limit)) err = 1'b1;
      ans.rec.stick_channels[11*i +: 11] = diff[10:0];
    end
    if (err) begin
      keys_now = '0;
      ans.rec = '0;
      ans.err = 1'b1;
    end else begin
      ans.rec.dial          = fr[143:128] - {5'd0, offset};
      ans.rec.switch_right  = sw_r;
      ans.rec.switch_left   = sw_l;
      ans.rec.mouse_x       = 16'h0 - fr[79:64];
      ans.rec.mouse_y       = 16'h0 - fr[63:48];
      ans.rec.mouse_z       = fr[95:80];
      ans.rec.mouse_buttons = fr[111:96];
      ans.rec.keys          = new_keys;
    end
    answers_due.push_back(ans);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    answer_t want;
    if (!rst_ni) begin
      byte_pos = '0;
      keys_now = '0;
      keys_changed = '0;
      keys_reported = '0;
      offset = OffsetReset;
      limit = LimitReset;
      answers_due.delete();
      mismatches_o = 0;
      pending_o <= 0;
    end else begin
      // results leave only after their input is registered, so check them first
      if (out_valid_i && !out_stall_i) begin
        if (answers_due.size() == 0) begin
          report("result transaction with nothing expected");
        end else begin
          want = answers_due.pop_front();
          check_field("result_kind", want.kind, result_kind_i);
          check_field("stick_channels", want.rec.stick_channels, stick_channels_i);
          check_field("dial", want.rec.dial, dial_i);
          check_field("switch_right", want.rec.switch_right, switch_right_i);
          check_field("switch_left", want.rec.switch_left, switch_left_i);
          check_field("mouse_x", want.rec.mouse_x, mouse_x_i);
          check_field("mouse_y", want.rec.mouse_y, mouse_y_i);
          check_field("mouse_z", want.rec.mouse_z, mouse_z_i);
          check_field("mouse_buttons", want.rec.mouse_buttons, mouse_buttons_i);
          check_field("keys", want.rec.keys, keys_i);
          check_field("frame_error", want.err, frame_error_i);
          check_field("key_once_hit", want.hit, key_once_hit_i);
        end
      end
      if (in_valid_i && !in_stall_i)
        decode_item(action_e'(action_i), rx_byte_i, frame_start_i, key_mask_i);
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_OFFSET: offset = cfg_data_i;
          CFG_LIMIT:  limit = cfg_data_i[9:0];
          default: ;
        endcase
      end
      pending_o <= answers_due.size();
    end
  end

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 100ps
module testbench;
  import rfd_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int HoldCycles = 150;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        action = 1'b0;
  logic [7:0]  rx_byte = '0;
  logic        frame_start = 1'b0;
  logic [15:0] key_mask = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        result_kind;
  logic [43:0] stick_channels;
  logic [15:0] dial;
  logic [1:0]  switch_right;
  logic [1:0]  switch_left;
  logic [15:0] mouse_x;
  logic [15:0] mouse_y;
  logic [15:0] mouse_z;
  logic [15:0] mouse_buttons;
  logic [15:0] keys;
  logic        frame_error;
  logic        key_once_hit;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [10:0] cfg_data = '0;

  int          mismatches;
  int          pending;
  int          cycle_count = 0;
  int          burst_left = 0;
  int unsigned hold_requests = 0;
  int unsigned hold_served = 0;
  logic        hold_off = 1'b0;
  int          stall_mode = 0;
  int          mode_left = 0;
  logic [3:0]  stall_tick = '0;
  logic [10:0] cur_offset = OffsetReset;
  logic [9:0]  cur_limit = LimitReset;
  logic [15:0] last_keys = '0;

  remote_frame_decoder dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .action_i(action), .rx_byte_i(rx_byte), .frame_start_i(frame_start),
    .key_mask_i(key_mask),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .result_kind_o(result_kind), .stick_channels_o(stick_channels), .dial_o(dial),
    .switch_right_o(switch_right), .switch_left_o(switch_left),
    .mouse_x_o(mouse_x), .mouse_y_o(mouse_y), .mouse_z_o(mouse_z),
    .mouse_buttons_o(mouse_buttons), .keys_o(keys),
    .frame_error_o(frame_error), .key_once_hit_o(key_once_hit),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  remote_frame_checker chk (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .action_i(action), .rx_byte_i(rx_byte), .frame_start_i(frame_start),
    .key_mask_i(key_mask),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .result_kind_i(result_kind), .stick_channels_i(stick_channels), .dial_i(dial),
    .switch_right_i(switch_right), .switch_left_i(switch_left),
    .mouse_x_i(mouse_x), .mouse_y_i(mouse_y), .mouse_z_i(mouse_z),
    .mouse_buttons_i(mouse_buttons), .keys_i(keys),
    .frame_error_i(frame_error), .key_once_hit_i(key_once_hit),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .mismatches_o(mismatches), .pending_o(pending)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // receiver: stall mode changes whenever mode_left runs out
  always @(posedge clk or negedge rst_n) begin : receiver
    logic s;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        mode_left <= $urandom_range(20, 300);
      end else begin
        mode_left <= mode_left - 1;
      end
      stall_tick <= stall_tick + 4'd1;
      case (stall_mode)
        0: s = 1'b0;
        1: s = ($urandom_range(0, 3) == 0);
        2: s = ($urandom_range(0, 3) != 0);
        default: s = stall_tick[2];
      endcase
      out_stall <= hold_off || s;
    end
  end

  // long receiver hold-off on request, so that the block backs up
  initial begin
    forever begin
      @(posedge clk);
      if (hold_requests != hold_served) begin
        hold_served = hold_requests;
        hold_off <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
        hold_off <= 1'b0;
      end
    end
  end

  task automatic put_item(input action_e act, input logic [7:0] rx, input logic st,
                          input logic [15:0] m);
    logic taken;
    action <= act;
    rx_byte <= rx;
    frame_start <= st;
    key_mask <= m;
    in_valid <= 1'b1;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                                : $urandom_range(0, 12);
    end
  endtask

  task automatic send_byte(input logic [7:0] rx, input logic st);
    put_item(ACT_BYTE, rx, st, 16'($urandom));
  endtask

  task automatic query(input logic [15:0] m);
    put_item(ACT_QUERY, 8'($urandom), 1'($urandom), m);
  endtask

  task automatic send_frame(input logic [143:0] fr);
    for (int i = 0; i < 18; i++) send_byte(fr[8*i +: 8], i == 0);
  endtask

  function automatic logic [143:0] make_frame(input logic [43:0] sticks,
      input logic [1:0] sw_r, input logic [1:0] sw_l, input logic [15:0] my_raw,
      input logic [15:0] mx_raw, input logic [15:0] z, input logic [15:0] btn,
      input logic [15:0] k, input logic [15:0] dial_word);
    return {dial_word, k, btn, z, mx_raw, my_raw, sw_l, sw_r, sticks};
  endfunction

  function automatic logic [10:0] pick_stick(input logic good);
    int lo;
    int hi;
    lo = int'(cur_offset) - int'(cur_limit);
    hi = int'(cur_offset) + int'(cur_limit);
    if (lo < 0) lo = 0;
    if (hi > 2047) hi = 2047;
    if (!good) return 11'($urandom_range(0, 2047));
    case ($urandom_range(0, 7))
      0: return 11'(lo);
      1: return 11'(hi);
      default: return 11'($urandom_range(lo, hi));
    endcase
  endfunction

  task automatic random_frame(input logic good);
    logic [43:0] sticks;
    logic [1:0]  sw_r;
    logic [1:0]  sw_l;
    logic [15:0] k;
    sticks = {pick_stick(good), pick_stick(good), pick_stick(good), pick_stick(good)};
    sw_r = good ? 2'($urandom_range(1, 3)) : 2'($urandom);
    sw_l = good ? 2'($urandom_range(1, 3)) : 2'($urandom);
    case ($urandom_range(0, 3))
      0: k = 16'($urandom);
      1: k = last_keys;
      default: k = last_keys ^ (16'h1 << $urandom_range(0, 15));
    endcase
    last_keys = k;
    send_frame(make_frame(sticks, sw_r, sw_l, 16'($urandom), 16'($urandom),
                          16'($urandom), 16'($urandom), k, 16'($urandom)));
  endtask

  task automatic random_query();
    case ($urandom_range(0, 4))
      0: query(16'h1 << $urandom_range(0, 15));
      1: query(16'($urandom));
      2: query(last_keys);
      3: query(last_keys & 16'($urandom));
      default: query(($urandom_range(0, 1) == 0) ? 16'hFFFF : 16'h0000);
    endcase
  endtask

  task automatic random_traffic(input int n);
    int count;
    int r;
    int len;
    count = 0;
    while (count < n) begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        random_frame(1'b1);
        count += 18;
      end else if (r < 58) begin
        random_frame(1'b0);
        count += 18;
      end else if (r < 83) begin
        random_query();
        count++;
      end else if (r < 93) begin
        // frame cut short, the next start restarts the count
        len = $urandom_range(1, 17);
        for (int i = 0; i < len; i++) send_byte(8'($urandom), i == 0);
        count += len;
      end else begin
        len = $urandom_range(1, 5);
        for (int i = 0; i < len; i++) send_byte(8'($urandom), 1'($urandom));
        count += len;
      end
    end
  endtask

  // sender pauses until every answer is in, then lets the pipeline drain
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input cfg_idx_e idx, input logic [10:0] val);
    logic ready;
    wait_idle();
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do begin
      @(negedge clk);
      ready = cfg_ready;
      @(posedge clk);
    end while (!ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_OFFSET) cur_offset = val;
    else cur_limit = val[9:0];
  endtask

  task automatic set_config(input logic [10:0] off, input logic [9:0] lim);
    cfg_write(CFG_OFFSET, off);
    cfg_write(CFG_LIMIT, {1'b0, lim});
  endtask

  initial begin
    logic [43:0] centre;
    centre = {4{11'd1024}};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, reset configuration
    query(16'h0001);
    send_frame(make_frame(centre, 2'd1, 2'd3, 16'h8000, 16'h0001, 16'hFFFF,
                          16'hFFFF, 16'hFFFF, 16'h0000));
    query(16'h0001);
    query(16'h0001);
    query(16'h0000);
    // sticks exactly at the limit either side
    send_frame(make_frame({11'd324, 11'd1724, 11'd324, 11'd1724}, 2'd2, 2'd2,
                          16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF));
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    query(16'h0001);
    send_frame(make_frame({11'd1725, 11'd1024, 11'd1024, 11'd1024}, 2'd3, 2'd3,
                          16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0, 16'h00FF, 16'h0400));
    query(16'hFFFF);
    send_frame(make_frame(centre, 2'd0, 2'd1, 16'h1111, 16'h2222, 16'h3333,
                          16'h4444, 16'h0F0F, 16'h5555));
    send_frame(make_frame(centre, 2'd3, 2'd0, 16'h1111, 16'h2222, 16'h3333,
                          16'h4444, 16'h0F0F, 16'h5555));
    // restart part-way through a frame
    for (int i = 0; i < 7; i++) send_byte(8'($urandom), i == 0);
    send_frame(make_frame(centre, 2'd1, 2'd1, 16'h7FFF, 16'hFFFF, 16'h0001,
                          16'h00FF, 16'h8001, 16'h7FFF));
    query(16'h8000);
    query(16'h0001);
    send_frame(make_frame(centre, 2'd1, 2'd2, 16'h0000, 16'h8000, 16'h7FFF,
                          16'hFF00, 16'h8001, 16'h8000));
    query(16'h8000);
    last_keys = 16'h8001;

    random_traffic(85);
    set_config(11'd0, 10'd1023);
    random_traffic(85);
    set_config(11'd2047, 10'd1023);
    random_traffic(85);
    set_config(11'd1024, 10'd0);
    random_traffic(85);
    set_config(11'($urandom), 10'($urandom));
    hold_requests <= hold_requests + 1;
    repeat (30) random_query();
    random_frame(1'b1);
    random_traffic(85);
    set_config(11'($urandom), 10'($urandom));
    random_traffic(85);

    wait_idle();
    repeat (10) @(posedge clk);
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
